// ===== rtl/sfir_pkg.sv =====
// Shared constants, coefficient tables and types for the stereo switchable FIR.
package sfir_pkg;

  localparam int HISTORY_DEPTH       = 21;
  localparam int LOWPASS_TAPS        = 20;
  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int COEF_FRAC_BITS_DEF  = 15;
  localparam int Q23_BITS            = 23;
  localparam int IDX_W               = $clog2(HISTORY_DEPTH);
  localparam int ACC_GUARD           = $clog2(HISTORY_DEPTH);

  // switch decode masks
  localparam logic [1:0] SW_LOWPASS_MASK  = 2'h1;
  localparam logic [1:0] SW_HIGHPASS_MASK = 2'h2;

  // master coefficients, signed Q0.23
  localparam int LP_Q23 [LOWPASS_TAPS] = '{
    -141954, 423100, 330162, 364169, 431001, 501811, 566133, 618999,
    656375, 675498, 675498, 656375, 618999, 566133, 501811, 431001,
    364169, 330162, 423100, -141954
  };

  localparam int HP_Q23 [HISTORY_DEPTH] = '{
    -330685, -49737, 120041, 341337, 483368, 406309, 36487, -581575,
    -1281664, -1834864, 6343537, -1834864, -1281664, -581575, 36487,
    406309, 483368, 341337, 120041, -49737, -330685
  };

  // round half away from zero from Q0.23 down to frac fractional bits
  function automatic int sfir_quant(input int c23, input int frac);
    int sh;
    longint mag;
    longint q;
    sh  = Q23_BITS - frac;
    mag = (c23 < 0) ? -longint'(c23) : longint'(c23);
    q   = mag;
    if (sh > 0) begin
      q = (mag + (longint'(1) << (sh - 1))) >> sh;
    end
    return (c23 < 0) ? int'(-q) : int'(q);
  endfunction

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } sfir_mac_ctl_t;

endpackage

// ===== rtl/sfir_cell.sv =====
// One delay-line cell holding a left and a right sample.
module sfir_cell #(
  parameter int SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] d_left,
  input  logic signed [SAMPLE_BITS-1:0] d_right,
  output logic signed [SAMPLE_BITS-1:0] q_left,
  output logic signed [SAMPLE_BITS-1:0] q_right
);
  import sfir_pkg::*;

  logic signed [SAMPLE_BITS-1:0] left_r;
  logic signed [SAMPLE_BITS-1:0] right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (en) begin
      left_r  <= d_left;
      right_r <= d_right;
    end
  end

  assign q_left  = left_r;
  assign q_right = right_r;

endmodule

// ===== rtl/sfir_mac.sv =====
// Multiply-accumulate unit with truncating scale-down and saturation.
module sfir_mac #(
  parameter int SAMPLE_BITS    = sfir_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = sfir_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  sfir_pkg::sfir_mac_ctl_t          ctl,
  input  logic signed [SAMPLE_BITS-1:0]    tap,
  input  logic signed [COEF_FRAC_BITS:0]   coef,
  output logic signed [SAMPLE_BITS-1:0]    y
);
  import sfir_pkg::*;

  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam int PROD_W = SAMPLE_BITS + COEF_W;
  localparam int ACC_W  = PROD_W + ACC_GUARD;

  localparam logic signed [ACC_W-1:0] RND_BIAS =
    (ACC_W'(1) << COEF_FRAC_BITS) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MAX =
    (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_adj;
  logic signed [ACC_W-1:0]  acc_scaled;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(tap) * PROD_W'(coef);
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // bias negatives so the arithmetic shift truncates toward zero
  always_comb begin
    acc_adj    = acc_r + (acc_r[ACC_W-1] ? RND_BIAS : '0);
    acc_scaled = acc_adj >>> COEF_FRAC_BITS;
    if (acc_scaled > Y_MAX) begin
      y = Y_MAX[SAMPLE_BITS-1:0];
    end else if (acc_scaled < Y_MIN) begin
      y = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y = acc_scaled[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/stereo_switchable_fir.sv =====
// Top level of the stereo switchable FIR filter (low-pass / high-pass / passthrough).
//
// Each accepted item pushes one left/right sample pair into a 21-cell delay
// line and returns one filtered (or passed) pair. switches bit 0 picks the
// 20-tap low-pass, else bit 1 picks the 21-tap high-pass, else the input pair
// is returned unchanged; the delay line is updated in every mode. The pair is
// shifted in at the accepting edge. A filtered item then runs through S_RUN,
// in which the cell ring rotates once past a single multiplier per channel,
// S_TAIL to drain the product register and S_FIN to scale, saturate and load
// the output register; a passthrough item goes straight to S_FIN. The next
// item is taken after the result enters the output register, so one item is
// in work at a time; a held out_stall costs nothing until the following
// result is ready. Coefficients are Q1.15 by default; sums are shifted right
// by COEF_FRAC_BITS toward zero and clamped to the signed SAMPLE_BITS range.
module stereo_switchable_fir #(
  parameter int SAMPLE_BITS    = sfir_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = sfir_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input item channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_right_sample,
  input  logic [1:0]                    in_switches,
  // result item channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out
);
  import sfir_pkg::*;

  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,   // waiting for an item
    S_RUN  = 4'b0010,   // ring rotating, one tap per cycle
    S_TAIL = 4'b0100,   // last product into the accumulator
    S_FIN  = 4'b1000    // result waiting for the output register
  } state_t;

  typedef enum logic [1:0] {
    M_PASS = 2'd0,
    M_LP   = 2'd1,
    M_HP   = 2'd2
  } mode_t;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  logic in_fire;
  logic out_free;
  logic fin_fire;
  logic chain_en;

  logic signed [SAMPLE_BITS-1:0] hist_l [HISTORY_DEPTH];
  logic signed [SAMPLE_BITS-1:0] hist_r [HISTORY_DEPTH];

  logic signed [COEF_W-1:0] lp_coef [HISTORY_DEPTH];
  logic signed [COEF_W-1:0] hp_coef [HISTORY_DEPTH];
  logic signed [COEF_W-1:0] coef_sel;

  sfir_mac_ctl_t mac_ctl;
  logic signed [SAMPLE_BITS-1:0] y_left;
  logic signed [SAMPLE_BITS-1:0] y_right;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r;
  logic signed [SAMPLE_BITS-1:0] out_right_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign fin_fire = (state_r == S_FIN) && out_free;

  // cells move on a new item (shift in) and on every rotation step
  assign chain_en = in_fire || (state_r == S_RUN);

  // Coefficient tables, quantized at elaboration. The low-pass table has no
  // entry for the oldest cell, so that tap weighs zero.
  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_coef
    assign hp_coef[g] = COEF_W'(sfir_quant(HP_Q23[g], COEF_FRAC_BITS));
    if (g < LOWPASS_TAPS) begin : g_lp
      assign lp_coef[g] = COEF_W'(sfir_quant(LP_Q23[g], COEF_FRAC_BITS));
    end else begin : g_lp_zero
      assign lp_coef[g] = '0;
    end
  end

  assign coef_sel = (mode_r == M_LP) ? lp_coef[idx_r] : hp_coef[idx_r];

  // Delay line as a ring: cell 0 takes the new sample on load and the oldest
  // cell's sample while rotating. After 21 rotations every sample is home.
  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_chain
    logic signed [SAMPLE_BITS-1:0] d_l;
    logic signed [SAMPLE_BITS-1:0] d_r;
    if (g == 0) begin : g_head
      assign d_l = in_fire ? in_left_sample  : hist_l[HISTORY_DEPTH-1];
      assign d_r = in_fire ? in_right_sample : hist_r[HISTORY_DEPTH-1];
    end else begin : g_body
      assign d_l = hist_l[g-1];
      assign d_r = hist_r[g-1];
    end
    sfir_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (chain_en),
      .d_left  (d_l),
      .d_right (d_r),
      .q_left  (hist_l[g]),
      .q_right (hist_r[g])
    );
  end

  // The oldest cell is the tap: at step idx it holds the sample of age idx.
  always_comb begin
    mac_ctl.clear  = in_fire;
    mac_ctl.mul_en = (state_r == S_RUN);
    mac_ctl.acc_en = ((state_r == S_RUN) && (idx_r != IDX_LAST)) || (state_r == S_TAIL);
  end

  sfir_mac #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mac_left (
    .clk  (clk),
    .ctl  (mac_ctl),
    .tap  (hist_l[HISTORY_DEPTH-1]),
    .coef (coef_sel),
    .y    (y_left)
  );

  sfir_mac #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mac_right (
    .clk  (clk),
    .ctl  (mac_ctl),
    .tap  (hist_r[HISTORY_DEPTH-1]),
    .coef (coef_sel),
    .y    (y_right)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          priority if ((in_switches & SW_LOWPASS_MASK) != '0) begin
            mode_nxt = M_LP;
          end else if ((in_switches & SW_HIGHPASS_MASK) != '0) begin
            mode_nxt = M_HP;
          end else begin
            mode_nxt = M_PASS;
          end
          idx_nxt = IDX_LAST;
          if (((in_switches & SW_LOWPASS_MASK) != '0) ||
              ((in_switches & SW_HIGHPASS_MASK) != '0)) begin
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_RUN: begin
        idx_nxt = idx_r - IDX_W'(1);
        if (idx_r == '0) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_PASS;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // output register; passthrough reads the newest sample back from cell 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_left_r  <= (mode_r == M_PASS) ? hist_l[0] : y_left;
      out_right_r <= (mode_r == M_PASS) ? hist_r[0] : y_right;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

endmodule

// ===== rtl/sfir_checker.sv =====
// Port-level checks for the stereo switchable FIR, bound to the top level.
module sfir_checker #(
  parameter int SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input logic signed [SAMPLE_BITS-1:0] in_right_sample,
  input logic [1:0]                    in_switches,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_left_out,
  input logic signed [SAMPLE_BITS-1:0] out_right_out
);
  import sfir_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // one item at a time: an accepted item closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after an accepted item");

  // a new result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result item appeared without work in progress");

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=>
      (in_valid && $stable(in_left_sample) && $stable(in_right_sample) &&
       $stable(in_switches)))
    else $error("stalled input item changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_left_out) && $stable(out_right_out)))
    else $error("stalled result item changed");

endmodule

bind stereo_switchable_fir sfir_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sfir_checker (.*);

// ===== test/tb.sv =====
// Self-checking testbench for stereo_switchable_fir: random and directed stereo items.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfir_pkg::*;

  localparam int SB        = SAMPLE_BITS_DEF;
  localparam int FRAC      = COEF_FRAC_BITS_DEF;
  localparam int Q_SHIFT   = Q23_BITS - FRAC;   // drop from Q0.23 to Q1.FRAC
  localparam int HOLD_LEN  = 300;               // long receiver hold-off, in cycles
  localparam int SETTLE    = 30;                // longer than the filter latency, in cycles
  localparam int LIMIT     = 400000;            // watchdog, cycles

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [1:0] SW_PASS = 2'd0;
  localparam logic [1:0] SW_BOTH = SW_LOWPASS_MASK | SW_HIGHPASS_MASK;

  // design coefficients, Q0.23; the checker quantizes them itself
  localparam int LP_TAPS_Q23 [LOWPASS_TAPS] = '{
    -141954, 423100, 330162, 364169, 431001, 501811, 566133, 618999,
    656375, 675498, 675498, 656375, 618999, 566133, 501811, 431001,
    364169, 330162, 423100, -141954
  };
  localparam int HP_TAPS_Q23 [HISTORY_DEPTH] = '{
    -330685, -49737, 120041, 341337, 483368, 406309, 36487, -581575,
    -1281664, -1834864, 6343537, -1834864, -1281664, -581575, 36487,
    406309, 483368, 341337, 120041, -49737, -330685
  };

  typedef struct {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic [1:0]           sw;
  } stereo_item_t;

  typedef struct {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } stereo_pair_t;

  // DUT hookup; every input starts at a known value
  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic signed [SB-1:0] in_left_sample  = '0;
  logic signed [SB-1:0] in_right_sample = '0;
  logic [1:0]           in_switches     = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic signed [SB-1:0] out_left_out;
  logic signed [SB-1:0] out_right_out;

  stereo_switchable_fir u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_switches     (in_switches),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus queue, expected output pairs, and the checker's own delay lines
  stereo_item_t pending_items[$];
  stereo_pair_t expected_pairs[$];
  longint       left_line [HISTORY_DEPTH];
  longint       right_line [HISTORY_DEPTH];

  // traffic knobs (changed only at the falling edge by the sequencer), the hold-off count and tallies
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned fail_count    = 0;
  longint      cycle_count   = 0;

  // mode runs for the random part: keep one switch setting for a while so the
  // filters reach steady state, with the odd stray value mixed in
  int unsigned run_left = 0;
  logic [1:0]  run_sw   = SW_PASS;

  stereo_item_t on_wire;

  initial begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      left_line[i]  = 0;
      right_line[i] = 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker model
  // ---------------------------------------------------------------------------

  // Q0.23 -> Q1.FRAC, ties rounded away from zero
  function automatic longint coef_q15(input int c23);
    longint mag;
    mag = (c23 < 0) ? -longint'(c23) : longint'(c23);
    mag = (mag + (longint'(1) << (Q_SHIFT - 1))) >>> Q_SHIFT;
    return (c23 < 0) ? -mag : mag;
  endfunction

  // drop the fraction toward zero, then clamp to the sample range
  function automatic logic signed [SB-1:0] scale_clamp(input longint acc);
    longint y;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SB - 1)) - 1;
    lo = -hi - 1;
    y  = (acc < 0) ? -((-acc) >>> FRAC) : (acc >>> FRAC);
    if (y > hi) begin
      y = hi;
    end else if (y < lo) begin
      y = lo;
    end
    return y[SB-1:0];
  endfunction

  // push one pair into both delay lines and compute the pair the block returns
  function automatic stereo_pair_t filter_pair(input stereo_item_t it);
    stereo_pair_t res;
    longint       acc_l;
    longint       acc_r;
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
      left_line[i]  = left_line[i-1];
      right_line[i] = right_line[i-1];
    end
    left_line[0]  = longint'(it.left);
    right_line[0] = longint'(it.right);
    acc_l = 0;
    acc_r = 0;
    if ((it.sw & SW_LOWPASS_MASK) != 0) begin
      // low-pass wins when both bits are set; newest 20 samples only
      for (int k = 0; k < LOWPASS_TAPS; k++) begin
        acc_l += coef_q15(LP_TAPS_Q23[k]) * left_line[k];
        acc_r += coef_q15(LP_TAPS_Q23[k]) * right_line[k];
      end
      res.left  = scale_clamp(acc_l);
      res.right = scale_clamp(acc_r);
    end else if ((it.sw & SW_HIGHPASS_MASK) != 0) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        acc_l += coef_q15(HP_TAPS_Q23[k]) * left_line[k];
        acc_r += coef_q15(HP_TAPS_Q23[k]) * right_line[k];
      end
      res.left  = scale_clamp(acc_l);
      res.right = scale_clamp(acc_r);
    end else begin
      res.left  = it.left;
      res.right = it.right;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_item(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r,
                          input logic [1:0] sw);
    stereo_item_t it;
    it.left  = l;
    it.right = r;
    it.sw    = sw;
    pending_items.push_back(it);
  endtask

  // mostly full-range noise, plus rail values and small signals near zero
  function automatic logic signed [SB-1:0] rand_sample();
    logic [31:0] raw;
    int          small_v;
    raw     = $urandom();
    small_v = int'($urandom_range(0, 511)) - 256;
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2, 3: return small_v[SB-1:0];
      default: return raw[SB-1:0];
    endcase
  endfunction

  task automatic add_random(input int unsigned n);
    logic [1:0] sw;
    for (int unsigned i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_sw   = 2'($urandom_range(0, 3));
        run_left = $urandom_range(1, 40);
      end
      run_left--;
      sw = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : run_sw;
      add_item(rand_sample(), rand_sample(), sw);
    end
  endtask

  // sender stays quiet until every expected pair has come back
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_pairs.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the next queued item when the slot is free; a stalled
  // item stays on the wires untouched. Valid is raised without looking at in_stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_pairs.push_back(filter_pair(on_wire));
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_wire          = pending_items.pop_front();
          in_valid        <= 1'b1;
          in_left_sample  <= on_wire.left;
          in_right_sample <= on_wire.right;
          in_switches     <= on_wire.sw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off counter, armed by a one-cycle request from the sequencer
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every taken output pair is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    stereo_pair_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pairs.size() == 0) begin
          note_fail($sformatf("unexpected output item: left %0d right %0d",
                              out_left_out, out_right_out));
        end else begin
          want = expected_pairs.pop_front();
          if (out_left_out !== want.left || out_right_out !== want.right) begin
            note_fail($sformatf("mismatch: left exp %0d got %0d, right exp %0d got %0d",
                                want.left, out_left_out, want.right, out_right_out));
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: all knob changes and queue fills happen at the falling edge
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: passthrough at the rails and around zero
    add_item('0, '0, SW_PASS);
    add_item(S_MAX, S_MIN, SW_PASS);
    add_item(S_MIN, S_MAX, SW_PASS);
    // constant full-scale input through the low-pass (gain > 1), at opposite rails;
    // alternate plain low-pass with both bits set, where low-pass must win
    for (int i = 0; i < 8; i++) begin
      add_item(S_MAX, S_MIN, (i % 2 == 0) ? SW_LOWPASS_MASK : SW_BOTH);
    end
    // alternating full-scale signs through the high-pass
    for (int i = 0; i < 8; i++) begin
      add_item((i % 2 == 0) ? S_MAX : S_MIN, (i % 2 == 0) ? S_MIN : S_MAX,
               SW_HIGHPASS_MASK);
    end
    add_item(-24'sd1, 24'sd1, SW_PASS);
    add_item(24'sd1, -24'sd1, SW_PASS);
    add_item('0, '0, SW_HIGHPASS_MASK);
    add_item('0, '0, SW_LOWPASS_MASK);
    drain();

    // slow receiver
    send_idle_pct = 28;
    recv_idle_pct = 86;
    add_random(240);
    drain();

    // back-pressure: receiver holds off for a long stretch while the sender
    // keeps offering, so the block fills and stalls its input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    @(negedge clk);
    hold_req = 1'b0;
    add_random(40);
    drain();

    // slow sender
    send_idle_pct = 86;
    recv_idle_pct = 28;
    add_random(220);
    drain();

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(230);
    drain();

    // let any stray late output show up before the verdict
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
